// ===== src/kerf_pkg.sv =====
// Shared types, codes and the key index table for the key event repeat filter.
package kerf_pkg;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  localparam int CODE_W   = 8;
  localparam int STAMP_W  = 63;
  localparam int INDEX_W  = 7;

  localparam logic [INDEX_W-1:0] MAP_UNKNOWN    = 7'd119;
  localparam logic [INDEX_W-1:0] MAP_MOUSE_BASE = 7'd114;
  localparam logic [CODE_W-1:0]  MOUSE_LAST     = 8'd4;
  localparam int                 MAP_TABLE_LEN  = 113;

  // Raw code for each compact index 0..112.
  localparam logic [CODE_W-1:0] CODE_OF_INDEX [MAP_TABLE_LEN] = '{
    8'd27,
    8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121,
    8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128, 8'd129, 8'd130, 8'd131,
    8'd132, 8'd133, 8'd134, 8'd135,
    8'd192, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd48,
    8'd189, 8'd187, 8'd8, 8'd9,
    8'd81, 8'd87, 8'd69, 8'd82, 8'd84, 8'd89, 8'd85, 8'd73, 8'd79, 8'd80, 8'd219,
    8'd221, 8'd220,
    8'd20, 8'd65, 8'd83, 8'd68, 8'd70, 8'd71, 8'd72, 8'd74, 8'd75, 8'd76, 8'd186,
    8'd222, 8'd13,
    8'd160, 8'd90, 8'd88, 8'd67, 8'd86, 8'd66, 8'd78, 8'd77, 8'd188, 8'd190, 8'd191,
    8'd161,
    8'd162, 8'd91, 8'd164, 8'd32, 8'd165, 8'd163,
    8'd44, 8'd145, 8'd19, 8'd45, 8'd36, 8'd33, 8'd46, 8'd35, 8'd34, 8'd38, 8'd37,
    8'd40, 8'd39,
    8'd144, 8'd111, 8'd106, 8'd109, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102,
    8'd103, 8'd104, 8'd105,
    8'd96, 8'd110, 8'd107
  };

  // Write port of the held-key map.
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    logic              held;
  } map_wr_t;

  // Compact key index of a raw code; mouse codes first, then the table.
  function automatic logic [INDEX_W-1:0] map_key(input logic [CODE_W-1:0] code);
    logic [INDEX_W-1:0] idx;
    idx = MAP_UNKNOWN;
    for (int i = MAP_TABLE_LEN - 1; i >= 0; i--) begin
      if (CODE_OF_INDEX[i] == code) begin
        idx = INDEX_W'(i);
      end
    end
    if (code <= MOUSE_LAST) begin
      idx = MAP_MOUSE_BASE + INDEX_W'(code);
    end
    return idx;
  endfunction

endpackage

// ===== src/kerf_ifs.sv =====
// Valid/ready channel interfaces for key events and records.
interface kerf_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [kerf_pkg::CODE_W-1:0]   key_code;
  logic                          key_pressed;
  logic [kerf_pkg::STAMP_W-1:0]  time_ns;

  modport source (output valid, kind, key_code, key_pressed, time_ns, input ready);
  modport sink   (input valid, kind, key_code, key_pressed, time_ns, output ready);
endinterface

interface kerf_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    sequence_res;
  logic [kerf_pkg::STAMP_W-1:0]  stamp_ns;
  logic                          released;
  logic [kerf_pkg::INDEX_W-1:0]  mapped_key;
  logic [kerf_pkg::CODE_W-1:0]   raw_code;

  modport source (output valid, sequence_res, stamp_ns, released, mapped_key, raw_code,
                  input ready);
  modport sink   (input valid, sequence_res, stamp_ns, released, mapped_key, raw_code,
                  output ready);
endinterface

// ===== src/key_event_repeat_filter_recorder_unit.sv =====
// Top level: key event repeat filter and recorder.
//
// Channels: evt takes one item per key event or command (kind, key_code,
// key_pressed, time_ns); rec gives one record item per event that is kept.
// Commands (start, stop, unused kind) and dropped events give no record.
//
// Throughput: one item per cycle, while no map sweep runs and rec takes its
// records. Each event reads the held-key map as it is accepted; a kept event
// writes its entry back as it leaves the decision stage. A one-entry forward
// register covers an event reading the entry the previous event just wrote.
//
// Path: a record reaches rec.valid through the decision stage and then the
// output register.
//
// Reset: capture goes off, the sequence number clears, and the map is swept
// to all keys released, one entry per cycle; evt.ready stays low during the
// sweep.
//
// Stall: while rec holds a record that is not taken, the decision stage may
// still take one item; the stage then holds and evt.ready drops.
module key_event_repeat_filter_recorder_unit #(
  parameter int KEY_CODES = 256
) (
  input  logic          clk,
  input  logic          rst,
  kerf_in_if.sink       evt,
  kerf_out_if.source    rec
);

  // Decision stage
  logic                          s1_valid;
  kerf_pkg::kind_t               s1_kind;
  logic [kerf_pkg::CODE_W-1:0]   s1_code;
  logic                          s1_pressed;
  logic [kerf_pkg::STAMP_W-1:0]  s1_time;

  // Last map write, for an event right behind it
  logic                          fwd_valid;
  logic [kerf_pkg::CODE_W-1:0]   fwd_addr;
  logic                          fwd_held;

  // Block state
  logic                          capture_on;
  logic                          capture_next;
  logic [7:0]                    record_count;
  logic [7:0]                    record_next;

  // Output register
  logic                          out_valid;
  logic [7:0]                    out_seq;
  logic [kerf_pkg::STAMP_W-1:0]  out_stamp;
  logic                          out_released;
  logic [kerf_pkg::INDEX_W-1:0]  out_key;
  logic [kerf_pkg::CODE_W-1:0]   out_raw_code;

  logic                          map_busy;
  logic                          rd_held;
  kerf_pkg::map_wr_t             map_wr;

  logic                          out_free;
  logic                          s1_adv;
  logic                          retire;
  logic                          held_now;
  logic                          in_range;
  logic                          emit;
  logic                          out_load;

  kerf_keymap #(
    .KEY_CODES (KEY_CODES)
  ) u_keymap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s1_adv),
    .rd_addr (evt.key_code),
    .rd_held (rd_held),
    .wr      (map_wr),
    .busy    (map_busy)
  );

  assign out_free  = !out_valid || rec.ready;
  assign s1_adv    = !s1_valid || out_free;
  assign evt.ready = s1_adv && !map_busy;
  assign retire    = s1_valid && out_free;

  // Take the bit just written when the same key comes right behind it.
  assign held_now = (fwd_valid && fwd_addr == s1_code) ? fwd_held : rd_held;
  assign in_range = {1'b0, s1_code} < 9'(KEY_CODES);

  // Keep an event only while capture is on and its code is in range; drop a press of a key that is already down.
  assign emit = s1_valid && s1_kind == kerf_pkg::KIND_EVENT && capture_on && in_range
                && !(held_now && s1_pressed);
  assign out_load = emit && out_free;

  always_comb begin
    map_wr.en   = out_load;
    map_wr.addr = s1_code;
    map_wr.held = s1_pressed;
  end

  always_comb begin
    capture_next = capture_on;
    record_next  = record_count;
    if (retire) begin
      case (s1_kind)
        kerf_pkg::KIND_START: begin
          capture_next = 1'b1;
          record_next  = '0;
        end
        kerf_pkg::KIND_STOP: begin
          capture_next = 1'b0;
        end
        kerf_pkg::KIND_EVENT: begin
          if (emit) begin
            record_next = record_count + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      fwd_valid    <= 1'b0;
      capture_on   <= 1'b0;
      record_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      capture_on   <= capture_next;
      record_count <= record_next;
      if (s1_adv) begin
        s1_valid  <= evt.valid && evt.ready;
        fwd_valid <= map_wr.en;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rec.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: advance with the stage, hold while it stalls.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_kind    <= kerf_pkg::kind_t'(evt.kind);
      s1_code    <= evt.key_code;
      s1_pressed <= evt.key_pressed;
      s1_time    <= evt.time_ns;
      fwd_addr   <= map_wr.addr;
      fwd_held   <= map_wr.held;
    end
    if (out_load) begin
      out_seq      <= record_count;
      out_stamp    <= s1_time;
      out_released <= !s1_pressed;
      out_key      <= kerf_pkg::map_key(s1_code);
      out_raw_code <= s1_code;
    end
  end

  assign rec.valid        = out_valid;
  assign rec.sequence_res = out_seq;
  assign rec.stamp_ns     = out_stamp;
  assign rec.released     = out_released;
  assign rec.mapped_key   = out_key;
  assign rec.raw_code     = out_raw_code;

  // A loaded record leaves its key state in the forward register.
  a_fwd_matches_record: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (fwd_valid && fwd_addr == out_raw_code && fwd_held == !out_released))
    else $error("forward register does not match the record just loaded");

  // Every record advances the sequence number by one.
  a_seq_advances: assert property (@(posedge clk) disable iff (rst)
    out_load |=> record_count == 8'($past(record_count) + 8'd1))
    else $error("sequence number did not advance with a record");

  // No item reaches the decision stage while the map is being swept.
  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (rst)
    map_busy |-> !s1_valid)
    else $error("item in decision stage during map sweep");

endmodule

// ===== src/kerf_keymap.sv =====
// Held-key map: one-bit synchronous memory with a clearing sweep after reset.
module kerf_keymap #(
  parameter int KEY_CODES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [kerf_pkg::CODE_W-1:0]  rd_addr,
  output logic                         rd_held,
  input  kerf_pkg::map_wr_t            wr,
  output logic                         busy
);

  localparam int AW = $clog2(KEY_CODES);

  logic          mem [KEY_CODES];
  logic          clearing;
  logic [AW-1:0] clr_idx;

  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  assign busy = clearing;

  // Sweep every entry to released, one a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(KEY_CODES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clearing | wr.en;
    wa = clearing ? clr_idx : wr.addr[AW-1:0];
    wd = clearing ? 1'b0 : wr.held;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_held <= mem[rd_addr[AW-1:0]];
    end
  end

endmodule
